>>> src/tss_pkg.sv
// Shared constants, codes and types of the TDMA slot scheduler.
// Used by tss_div, tss_flag_mem and tdma_slot_scheduler; depends on nothing.
package tss_pkg;

    // Scheduler geometry
    localparam int NUM_SLOTS    = 50;
    localparam int ACTIVE_TICKS = 327;
    localparam int SLEEP_TICKS  = 327;
    localparam int SLOT_PERIOD  = ACTIVE_TICKS + SLEEP_TICKS;

    // Field widths
    localparam int OP_W      = 3;
    localparam int TICK_W    = 15;
    localparam int SLOT_IDX_W = 6;
    localparam int LOAD_W    = 32;
    localparam int DISP_W    = 3;
    localparam int RTC_W     = 17;
    localparam int CNT_W     = 32;
    localparam int FLAG_W    = 2;

    localparam int TICK_RANGE      = 32768;
    localparam int SECONDS_PER_DAY = 86400;

    // Internal widths
    localparam int SLOT_W   = $clog2(NUM_SLOTS);
    localparam int PERIOD_W = $clog2(SLOT_PERIOD + 1);
    localparam int QUOT_W   = $clog2(TICK_RANGE / SLOT_PERIOD + 1);
    localparam int PROD_W   = PERIOD_W + SLOT_W;

    // Reciprocal of the slot period: exact quotient for every tick count
    localparam int RECIP_SHIFT  = TICK_W + PERIOD_W;
    localparam int RECIP_MUL    = ((1 << RECIP_SHIFT) + SLOT_PERIOD - 1) / SLOT_PERIOD;
    localparam int RECIP_W      = $clog2(RECIP_MUL + 1);
    localparam int RECIP_PROD_W = TICK_W + RECIP_W;

    // Stream payload layout
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 104;

    // Flag bits of a table entry
    localparam int FLAG_RX_BIT = 0;
    localparam int FLAG_TX_BIT = 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TIMER      = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE_SLOT = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_RTC   = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD_NONCE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL  = 3'd4;

    // Dispatch codes
    localparam logic [DISP_W-1:0] DISP_NONE   = 3'd0;
    localparam logic [DISP_W-1:0] DISP_TX     = 3'd1;
    localparam logic [DISP_W-1:0] DISP_RX     = 3'd2;
    localparam logic [DISP_W-1:0] DISP_SLOT1  = 3'd3;
    localparam logic [DISP_W-1:0] DISP_MISSED = 3'd4;

    typedef struct packed {
        logic              en;
        logic              clear;
        logic [SLOT_W-1:0] addr;
        logic [FLAG_W-1:0] data;
    } flag_wr_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [TICK_W-1:0] rem;
    } div_res_t;

endpackage

>>> src/tss_div.sv
// Slot divider: tick count by the slot period through a reciprocal multiply,
// then the remainder by a multiply-subtract; done rises as the remainder is registered. Depends on tss_pkg.
module tss_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tss_pkg::TICK_W-1:0]  dividend,
    output tss_pkg::div_res_t           res
);

    logic                              quot_en_reg, quot_en_next;
    logic                              rem_en_reg, rem_en_next;
    logic                              done_reg, done_next;
    logic [tss_pkg::TICK_W-1:0]        tick_reg, tick_next;
    logic [tss_pkg::QUOT_W-1:0]        quot_reg, quot_next;
    logic [tss_pkg::TICK_W-1:0]        rem_reg, rem_next;
    logic [tss_pkg::RECIP_PROD_W-1:0]  recip_prod;
    logic [tss_pkg::PROD_W-1:0]        back_prod;

    assign recip_prod = tss_pkg::RECIP_PROD_W'(tick_reg) *
                        tss_pkg::RECIP_PROD_W'(tss_pkg::RECIP_MUL);
    assign back_prod  = tss_pkg::PROD_W'(tss_pkg::SLOT_PERIOD) *
                        tss_pkg::PROD_W'(quot_reg);

    always_comb
    begin
        quot_en_next = start;
        rem_en_next  = quot_en_reg;
        done_next    = rem_en_reg;
        tick_next    = tick_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        if (start)
            tick_next = dividend;
        if (quot_en_reg)
            quot_next = tss_pkg::QUOT_W'(recip_prod >> tss_pkg::RECIP_SHIFT);
        // take the quotient back off the tick count
        if (rem_en_reg)
            rem_next = tss_pkg::TICK_W'(tss_pkg::PROD_W'(tick_reg) - back_prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_en_reg <= 1'b0;
            rem_en_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            quot_en_reg <= quot_en_next;
            rem_en_reg  <= rem_en_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg <= tick_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule

>>> src/tss_flag_mem.sv
// Slot flag table: one write port, one registered read port, and a valid bit
// per entry so reset and clear-all empty the table at once. Depends on tss_pkg.
module tss_flag_mem
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  tss_pkg::flag_wr_t                  wr,
    input  logic [tss_pkg::SLOT_W-1:0]         raddr,
    output logic [tss_pkg::FLAG_W-1:0]         rdata
);

    logic [tss_pkg::FLAG_W-1:0]    mem [tss_pkg::NUM_SLOTS];
    logic [tss_pkg::NUM_SLOTS-1:0] valid_reg;
    logic [tss_pkg::FLAG_W-1:0]    rd_data_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.clear)
                valid_reg <= '0;
            else if (wr.en)
                valid_reg[wr.addr] <= 1'b1;
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    // an entry never written since the last clear reads as zero
    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> src/tdma_slot_scheduler.sv
// TDMA slot scheduler: sequencer, clocks and result register.
// Depends on tss_pkg, tss_div and tss_flag_mem.
//
// Usage: one item enters on the s_axis channel (operation in tuser, the other
// fields in tdata) and one result item leaves on m_axis (dispatch in tuser).
// A timer event divides the tick count by the slot period in the divider
// (reciprocal multiply, then multiply-subtract), reads the slot's flags
// from the table, then walks the table one slot per cycle until it reaches a
// flagged slot or wraps to slot 0. A missed slot goes straight from the
// divider to the result; flag writes, loads and clear-all go from accept
// straight to the result state. The result item becomes valid in the same
// cycle as the next item can be taken. Apart from output back-pressure, the
// scan length is what sets the worst case.
// s_axis_tready is high only while the sequencer is idle; it stays high when
// a finished result still waits in the output register, but the next result
// is held until m_axis_tready takes the previous one.
// Reset empties the slot table, zeroes RTC, uptime and nonce and drops any
// pending result.
module tdma_slot_scheduler
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: ticks[14:0], slot_index[20:15], tx_flag[21], rx_flag[22],
    //        load_value[54:23], zero[55]
    input  logic [tss_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: operation[2:0]
    input  logic [tss_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: current_slot[5:0], next_compare[20:6], second_tick[21],
    //        rtc_seconds[38:22], uptime_seconds[70:39], nonce_value[102:71],
    //        accepted[103]
    output logic [tss_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser: dispatch[2:0]
    output logic [tss_pkg::DISP_W-1:0]       m_axis_tuser
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_LOOK = 3'd2;
    localparam logic [2:0] ST_FLAG = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]                       state_reg, state_next;
    logic [tss_pkg::RTC_W-1:0]        rtc_reg, rtc_next;
    logic [tss_pkg::CNT_W-1:0]        uptime_reg, uptime_next;
    logic [tss_pkg::CNT_W-1:0]        nonce_reg, nonce_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [tss_pkg::OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [tss_pkg::DISP_W-1:0]       m_tuser_reg, m_tuser_next;

    logic [tss_pkg::SLOT_W-1:0]       scan_reg, scan_next;
    logic [tss_pkg::SLOT_W-1:0]       chk_reg, chk_next;
    logic [tss_pkg::DISP_W-1:0]       res_disp_reg, res_disp_next;
    logic [tss_pkg::SLOT_W-1:0]       res_slot_reg, res_slot_next;
    logic [tss_pkg::TICK_W-1:0]       res_cmp_reg, res_cmp_next;
    logic                             res_sec_reg, res_sec_next;
    logic                             res_acc_reg, res_acc_next;

    logic [tss_pkg::OP_W-1:0]         in_op;
    logic [tss_pkg::TICK_W-1:0]       in_ticks;
    logic [tss_pkg::SLOT_IDX_W-1:0]   in_idx;
    logic                             in_tx;
    logic                             in_rx;
    logic [tss_pkg::LOAD_W-1:0]       in_load;
    logic                             in_fire;

    tss_pkg::flag_wr_t                flag_wr;
    logic [tss_pkg::FLAG_W-1:0]       flag_rdata;
    tss_pkg::div_res_t                div_res;
    logic                             div_start;

    logic [tss_pkg::SLOT_W-1:0]       scan_succ;
    logic [tss_pkg::SLOT_W-1:0]       found_slot;
    logic [tss_pkg::PROD_W-1:0]       cmp_prod;
    logic [tss_pkg::SLOT_W-1:0]       div_slot;
    logic                             div_missed;

    assign in_op    = s_axis_tuser;
    assign in_ticks = s_axis_tdata[14:0];
    assign in_idx   = s_axis_tdata[20:15];
    assign in_tx    = s_axis_tdata[21];
    assign in_rx    = s_axis_tdata[22];
    assign in_load  = s_axis_tdata[54:23];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign div_start     = in_fire && (in_op == tss_pkg::OP_TIMER);

    tss_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (in_ticks),
        .res      (div_res)
    );

    tss_flag_mem u_flag_mem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (flag_wr),
        .raddr (scan_reg),
        .rdata (flag_rdata)
    );

    assign scan_succ  = (scan_reg == tss_pkg::SLOT_W'(tss_pkg::NUM_SLOTS - 1))
                        ? '0 : scan_reg + tss_pkg::SLOT_W'(1);
    assign div_slot   = tss_pkg::SLOT_W'(div_res.quot);
    assign div_missed = (32'(div_res.quot) >= 32'(tss_pkg::NUM_SLOTS)) ||
                        (32'(div_res.rem) >= 32'(tss_pkg::ACTIVE_TICKS));
    assign cmp_prod   = tss_pkg::PROD_W'(tss_pkg::SLOT_PERIOD) *
                        tss_pkg::PROD_W'(found_slot);

    always_comb
    begin
        state_next    = state_reg;
        rtc_next      = rtc_reg;
        uptime_next   = uptime_reg;
        nonce_next    = nonce_reg;
        m_tvalid_next = m_tvalid_reg && !m_axis_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        scan_next     = scan_reg;
        chk_next      = chk_reg;
        res_disp_next = res_disp_reg;
        res_slot_next = res_slot_reg;
        res_cmp_next  = res_cmp_reg;
        res_sec_next  = res_sec_reg;
        res_acc_next  = res_acc_reg;
        found_slot    = '0;
        flag_wr.en    = 1'b0;
        flag_wr.clear = 1'b0;
        flag_wr.addr  = tss_pkg::SLOT_W'(in_idx);
        flag_wr.data  = {in_tx, in_rx};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_disp_next = tss_pkg::DISP_NONE;
                    res_slot_next = '0;
                    res_cmp_next  = '0;
                    res_sec_next  = 1'b0;
                    res_acc_next  = 1'b0;
                    state_next    = ST_DONE;
                    case (in_op)
                        tss_pkg::OP_TIMER:
                        begin
                            state_next = ST_DIV;
                        end
                        tss_pkg::OP_WRITE_SLOT:
                        begin
                            if (7'(in_idx) < 7'(tss_pkg::NUM_SLOTS))
                            begin
                                flag_wr.en   = 1'b1;
                                res_acc_next = 1'b1;
                            end
                        end
                        tss_pkg::OP_LOAD_RTC:
                        begin
                            if (in_load < 32'(tss_pkg::SECONDS_PER_DAY))
                            begin
                                rtc_next     = in_load[tss_pkg::RTC_W-1:0];
                                res_acc_next = 1'b1;
                            end
                        end
                        tss_pkg::OP_LOAD_NONCE:
                        begin
                            nonce_next   = in_load;
                            res_acc_next = 1'b1;
                        end
                        tss_pkg::OP_CLEAR_ALL:
                        begin
                            flag_wr.clear = 1'b1;
                            res_acc_next  = 1'b1;
                        end
                        default:
                        begin
                            res_acc_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    if (div_missed)
                    begin
                        res_disp_next = tss_pkg::DISP_MISSED;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        res_slot_next = div_slot;
                        scan_next     = div_slot;
                        state_next    = ST_LOOK;
                        // slot 0 advances the clocks
                        if (div_slot == '0)
                        begin
                            res_sec_next = 1'b1;
                            uptime_next  = uptime_reg + tss_pkg::CNT_W'(1);
                            nonce_next   = nonce_reg + tss_pkg::CNT_W'(1);
                            if (rtc_reg >= tss_pkg::RTC_W'(tss_pkg::SECONDS_PER_DAY - 1))
                                rtc_next = '0;
                            else
                                rtc_next = rtc_reg + tss_pkg::RTC_W'(1);
                        end
                    end
                end
            end
            ST_LOOK:
            begin
                chk_next   = scan_reg;
                scan_next  = scan_succ;
                state_next = ST_FLAG;
            end
            ST_FLAG:
            begin
                // flag_rdata holds the current slot's entry
                if (chk_reg == tss_pkg::SLOT_W'(1))
                    res_disp_next = tss_pkg::DISP_SLOT1;
                else if (flag_rdata[tss_pkg::FLAG_TX_BIT])
                    res_disp_next = tss_pkg::DISP_TX;
                else if (flag_rdata[tss_pkg::FLAG_RX_BIT])
                    res_disp_next = tss_pkg::DISP_RX;
                else
                    res_disp_next = tss_pkg::DISP_NONE;
                if (scan_reg == '0)
                begin
                    found_slot   = '0;
                    res_cmp_next = tss_pkg::TICK_W'(cmp_prod);
                    state_next   = ST_DONE;
                end
                else
                begin
                    chk_next   = scan_reg;
                    scan_next  = scan_succ;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // flag_rdata holds the entry of chk_reg; scan_reg is being read
                if (flag_rdata != '0)
                begin
                    found_slot   = chk_reg;
                    res_cmp_next = tss_pkg::TICK_W'(cmp_prod);
                    state_next   = ST_DONE;
                end
                else if (scan_reg == '0)
                begin
                    found_slot   = '0;
                    res_cmp_next = tss_pkg::TICK_W'(cmp_prod);
                    state_next   = ST_DONE;
                end
                else
                begin
                    chk_next  = scan_reg;
                    scan_next = scan_succ;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_disp_reg;
                    m_tdata_next  = {res_acc_reg, nonce_reg, uptime_reg, rtc_reg,
                                     res_sec_reg, res_cmp_reg,
                                     tss_pkg::SLOT_IDX_W'(res_slot_reg)};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rtc_reg      <= '0;
            uptime_reg   <= '0;
            nonce_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rtc_reg      <= rtc_next;
            uptime_reg   <= uptime_next;
            nonce_reg    <= nonce_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        scan_reg     <= scan_next;
        chk_reg      <= chk_next;
        res_disp_reg <= res_disp_next;
        res_slot_reg <= res_slot_next;
        res_cmp_reg  <= res_cmp_next;
        res_sec_reg  <= res_sec_next;
        res_acc_reg  <= res_acc_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    a_rtc_in_day: assert property (@(posedge clk) disable iff (!rst_n)
        rtc_reg < tss_pkg::RTC_W'(tss_pkg::SECONDS_PER_DAY))
        else $error("rtc left the day range");

    a_missed_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tuser_reg == tss_pkg::DISP_MISSED) |->
        (m_tdata_reg[5:0] == '0 && m_tdata_reg[20:6] == '0 && !m_tdata_reg[21]))
        else $error("missed slot result carries slot, compare or second tick");

    a_second_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[21]) |-> (m_tdata_reg[5:0] == '0))
        else $error("second tick on a slot other than zero");

    a_scan_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (chk_reg != '0))
        else $error("scan checks slot zero");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("sequencer idle right after an accepted item");

endmodule
